// ===== design/scalar_kalman_filter_defines.svh =====
// Shared assertion macros for the scalar Kalman filter.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/skf_pkg.sv =====
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 2;

    // shared multiplier operand and product widths
    localparam int MA_W   = DATA_W + 2;
    localparam int MB_W   = GAIN_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/skf_div.sv =====
// Restoring radix-2 divider: quot = floor(numer * 2^GAIN_BITS / denom).
// One quotient bit per cycle; the result must fit GAIN_W bits.
module skf_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [skf_pkg::DATA_W-1:0]       i_numer,
    input  logic [skf_pkg::DEN_W-1:0]        i_denom,
    output skf_pkg::t_div_stat               o_stat,
    output logic [skf_pkg::GAIN_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(skf_pkg::GAIN_W + 1);

    logic [skf_pkg::REM_W-1:0]  r_rem;
    logic [skf_pkg::DEN_W-1:0]  r_den;
    logic [skf_pkg::GAIN_W-1:0] r_nsh;
    logic [skf_pkg::GAIN_W-1:0] r_quot;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [skf_pkg::REM_W-1:0]  shifted;
    logic [skf_pkg::REM_W:0]    trial;
    logic                       qbit;

    always_comb begin
        shifted = {r_rem[skf_pkg::REM_W-2:0], r_nsh[skf_pkg::GAIN_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        qbit    = ~trial[skf_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(skf_pkg::GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {3'b000, i_numer[skf_pkg::DATA_W-1:1]};
            r_nsh  <= {i_numer[0], {skf_pkg::GAIN_BITS{1'b0}}};
            r_den  <= i_denom;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= qbit ? trial[skf_pkg::REM_W-1:0] : shifted;
            r_nsh  <= {r_nsh[skf_pkg::GAIN_W-2:0], 1'b0};
            r_quot <= {r_quot[skf_pkg::GAIN_W-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ===== design/scalar_kalman_filter.sv =====
// Scalar Kalman filter over a stream of signed position samples.
//
// Input channel (i_valid/o_ready) carries one sample and a restart flag per
// beat. Output channel (o_valid/i_ready) returns the new estimate, the gain
// used, the new variance and a saturation flag: one result beat per input.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes measure
// noise, process noise and initial variance; write only while idle.
//
// Each sample runs through the 17-step radix-2 gain divider; one shared
// multiplier then does the estimate and variance products in consecutive
// states S_MUL1 and S_EST. One item is in work at a time, so a new sample
// is not taken until the current result has been loaded for output.
// The result sits in an output register: o_ready returns once it is loaded,
// so the next sample can be taken while that result waits. If the receiver
// stalls, the next result waits in the final state until the slot frees.
// Reset clears the estimate and variance and the primed flag, so the first
// sample restarts the filter; config registers return to their defaults.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]   i_sample,
    input  logic                                i_restart,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [skf_pkg::DATA_W-1:0]   o_filtered,
    output logic [skf_pkg::GAIN_W-1:0]          o_gain,
    output logic [skf_pkg::DATA_W-1:0]          o_variance,
    output logic                                o_variance_saturated,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data
);

    `include "scalar_kalman_filter_defines.svh"

    localparam int DW = skf_pkg::DATA_W;
    localparam int PW = skf_pkg::PROD_W;
    localparam int GB = skf_pkg::GAIN_BITS;

    // register defaults: 1.0 and 0.1 (rounded) in the sample format
    localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
    localparam logic [DW-1:0] RST_ONE  = DW'(ONE_L);
    localparam logic [DW-1:0] RST_PNS  = DW'((ONE_L + 64'd5) / 64'd10);
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (GB - 1);

    localparam logic signed [DW-1:0] EST_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] EST_MIN = {1'b1, {(DW-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_EST  = 3'd4;
    localparam logic [2:0] S_VAR  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;

    // config
    logic [DW-1:0]              r_meas;
    logic [DW-1:0]              r_pnoise;
    logic [DW-1:0]              r_init_var;

    // filter state
    logic signed [DW-1:0]       r_est;
    logic [DW-1:0]              r_var;
    logic                       r_primed;

    // per-item work
    logic signed [DW-1:0]       r_sample;
    logic                       r_den_zero;
    logic [skf_pkg::GAIN_W-1:0] r_gain;
    logic signed [PW-1:0]       r_prod;
    logic                       r_sat;

    // output slot
    logic                       r_out_valid;
    logic signed [DW-1:0]       r_out_filt;
    logic [skf_pkg::GAIN_W-1:0] r_out_gain;
    logic [DW-1:0]              r_out_var;
    logic                       r_out_sat;

    logic                       in_fire;
    logic                       out_free;
    logic [skf_pkg::DEN_W-1:0]  den_sum;
    logic                       div_start;
    skf_pkg::t_div_stat         div_stat;
    logic [skf_pkg::GAIN_W-1:0] div_quot;

    // shared multiplier
    logic signed [skf_pkg::MA_W-1:0] mul_a;
    logic signed [skf_pkg::MB_W-1:0] mul_b;
    logic signed [PW-1:0]            mul_p;

    logic signed [DW:0]         diff;
    logic [PW-1:0]              rnd;
    logic signed [PW-GB-1:0]    corr;
    logic signed [PW-GB:0]      est_sum;
    logic signed [DW-1:0]       est_new;
    logic [DW+1:0]              var_scaled;
    logic [DW+1:0]              var_tot;

    assign in_fire     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign den_sum     = {1'b0, r_var} + {1'b0, r_meas};
    assign div_start   = (r_state == S_DEN);

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (r_var),
        .i_denom (den_sum),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // innovation and multiplier operand select
    always_comb begin
        diff = {r_sample[DW-1], r_sample} - {r_est[DW-1], r_est};
        if (r_state == S_MUL1) begin
            mul_a = {diff[DW], diff};
            mul_b = {1'b0, r_gain};
        end else begin
            mul_a = {2'b00, r_var};
            mul_b = {1'b0, skf_pkg::GAIN_ONE - r_gain};
        end
        mul_p = mul_a * mul_b;
    end

    // round half up, clip the estimate to the signed range and add process noise to the scaled variance
    always_comb begin
        rnd     = r_prod + HALF_LSB;
        corr    = rnd[PW-1:GB];
        est_sum = {{(PW-GB-DW+1){r_est[DW-1]}}, r_est} + {corr[PW-GB-1], corr};
        if (est_sum > $signed({{(PW-GB-DW+1){1'b0}}, EST_MAX}))
            est_new = EST_MAX;
        else if (est_sum < $signed({{(PW-GB-DW+1){1'b1}}, EST_MIN}))
            est_new = EST_MIN;
        else
            est_new = est_sum[DW-1:0];
        var_scaled = rnd[GB+DW+1:GB];
        var_tot    = var_scaled + {2'b00, r_pnoise};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_DEN;
            S_DEN:   n_state = S_DIV;
            S_DIV:   if (div_stat.done) n_state = S_MUL1;
            S_MUL1:  n_state = S_EST;
            S_EST:   n_state = S_VAR;
            S_VAR:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    function automatic logic [DW-1:0] var_clip(input logic [DW+1:0] v);
        var_clip = (|v[DW+1:DW]) ? {DW{1'b1}} : v[DW-1:0];
    endfunction

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_meas      <= RST_ONE;
            r_pnoise    <= RST_PNS;
            r_init_var  <= RST_ONE;
            r_est       <= '0;
            r_var       <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    skf_pkg::CFG_MEAS_NOISE: r_meas     <= i_cfg_data;
                    skf_pkg::CFG_PROC_NOISE: r_pnoise   <= i_cfg_data;
                    skf_pkg::CFG_INIT_VAR:   r_init_var <= i_cfg_data;
                    default: ;
                endcase
            end

            // restart loads the estimate from the sample itself
            if (in_fire && (i_restart || !r_primed)) begin
                r_est    <= i_sample;
                r_var    <= r_init_var;
                r_primed <= 1'b1;
            end

            if (r_state == S_EST)
                r_est <= est_new;
            if (r_state == S_VAR)
                r_var <= var_clip(var_tot);

            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire)
            r_sample <= i_sample;
        if (r_state == S_DEN)
            r_den_zero <= (den_sum == '0);
        if (r_state == S_DIV && div_stat.done)
            r_gain <= r_den_zero ? '0 : div_quot;
        if (r_state == S_MUL1 || r_state == S_EST)
            r_prod <= mul_p;
        if (r_state == S_VAR)
            r_sat <= |var_tot[DW+1:DW];
        if (r_state == S_OUT && out_free) begin
            r_out_filt <= r_est;
            r_out_gain <= r_gain;
            r_out_var  <= r_var;
            r_out_sat  <= r_sat;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_filtered           = r_out_filt;
    assign o_gain               = r_out_gain;
    assign o_variance           = r_out_var;
    assign o_variance_saturated = r_out_sat;

    // divider only runs inside the divide step
    `SKF_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, div_stat.busy || div_stat.done,
        r_state == S_DIV, "divider active outside divide state")
    // gain is never above one
    `SKF_ASSERT_IMP(a_gain_range, i_clk, i_rst_n, o_valid,
        o_gain <= skf_pkg::GAIN_ONE, "gain above one")
    // a clipped variance reads as all ones
    `SKF_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, o_valid && o_variance_saturated,
        o_variance == {DW{1'b1}}, "saturated variance not at maximum")
    // an accepted sample makes the block busy
    `SKF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready,
        !o_ready, "ready held after accept")

endmodule
